// ----- src/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared types and constants of the row-diagonal parity encoder.
// ----------------------------------------------------------------------------
package rdp_pkg;

  // stripe geometry limits
  localparam int MAX_PRIME        = 17;
  localparam int MAX_SYMBOL_WORDS = 16;
  localparam int STORE_DEPTH      = (MAX_PRIME - 1) * MAX_SYMBOL_WORDS;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);
  localparam int DATA_W           = 64;
  localparam int CFG_W            = 5;
  localparam int FIELD_W          = 4;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_ROW_RD  = 2'd1,
    REQ_DIAG_RD = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_CHUNKS = 2'd0,
    CFG_PRIME      = 2'd1,
    CFG_SYM_WORDS  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // input item
  typedef struct packed {
    req_t                req_type;
    logic [FIELD_W-1:0]  chunk_index;
    logic [FIELD_W-1:0]  row_index;
    logic [FIELD_W-1:0]  word_index;
    logic [DATA_W-1:0]   data_word;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [DATA_W-1:0] parity_word;
    logic              status;
  } out_item_t;

  // current configuration
  typedef struct packed {
    logic [CFG_W-1:0] num_data_chunks;
    logic [CFG_W-1:0] prime_p;
    logic [CFG_W-1:0] symbol_words;
  } cfg_t;

  // decoded access plan for one item
  typedef struct packed {
    logic              err;
    logic [ADDR_W-1:0] row_addr;
    logic [ADDR_W-1:0] diag_addr;
    logic              diag_en;
    logic              row_fold;
  } rdp_plan_t;

endpackage

// ----- src/rdp_ram.sv -----
// ----------------------------------------------------------------------------
// rdp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rdp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rdp_decode.sv -----
// ----------------------------------------------------------------------------
// rdp_decode
// Range checks and row / diagonal address generation for one item.
// ----------------------------------------------------------------------------
module rdp_decode (
  input  rdp_pkg::in_item_t  item,
  input  rdp_pkg::cfg_t      cfg,
  output rdp_pkg::rdp_plan_t plan
);
  import rdp_pkg::*;

  logic             cfg_ok;
  logic             idx_ok;
  logic             chunk_ok;
  logic [CFG_W:0]   p_ext;
  logic [CFG_W:0]   k_ext;
  logic [CFG_W:0]   p_m1;
  logic [CFG_W:0]   dsum;
  logic [CFG_W:0]   diag;
  logic [CFG_W:0]   rsum;
  logic [CFG_W:0]   prow;
  logic [CFG_W:0]   row_ext;
  logic [FIELD_W:0] row_sel;

  assign p_ext   = {1'b0, cfg.prime_p};
  assign k_ext   = {1'b0, cfg.num_data_chunks};
  assign p_m1    = p_ext - (CFG_W+1)'(1);
  assign row_ext = (CFG_W+1)'(item.row_index);

  // configuration and index range checks
  assign cfg_ok = (cfg.num_data_chunks != '0) && (p_ext >= k_ext + (CFG_W+1)'(1)) &&
                  (p_ext <= (CFG_W+1)'(MAX_PRIME)) && (cfg.symbol_words != '0) &&
                  ((CFG_W+1)'(cfg.symbol_words) <= (CFG_W+1)'(MAX_SYMBOL_WORDS));
  assign idx_ok = (row_ext < p_m1) && (row_ext < (CFG_W+1)'(MAX_PRIME - 1)) &&
                  ((CFG_W+1)'(item.word_index) < (CFG_W+1)'(cfg.symbol_words));
  assign chunk_ok = (CFG_W+1)'(item.chunk_index) < k_ext;

  // diagonal of a written word: (chunk + row) mod p, below 2p when in range
  assign dsum = (CFG_W+1)'(item.chunk_index) + row_ext;
  assign diag = (dsum >= p_ext) ? dsum - p_ext : dsum;

  // row of the row-parity column on a diagonal: (row + p - k) mod p
  assign rsum = row_ext + p_ext - k_ext;
  assign prow = (rsum >= p_ext) ? rsum - p_ext : rsum;

  always_comb begin
    plan.err = 1'b0;
    if (item.req_type != REQ_CLEAR) begin
      plan.err = !cfg_ok || !idx_ok || ((item.req_type == REQ_WRITE) && !chunk_ok);
    end
    plan.diag_en  = (diag != p_m1);
    plan.row_fold = (prow != p_m1);
    row_sel = (item.req_type == REQ_DIAG_RD) ? prow[FIELD_W:0] : {1'b0, item.row_index};
    plan.row_addr = ADDR_W'(row_sel) * ADDR_W'(MAX_SYMBOL_WORDS) +
                    ADDR_W'(item.word_index);
    plan.diag_addr = (item.req_type == REQ_DIAG_RD) ?
                     ADDR_W'(item.row_index) * ADDR_W'(MAX_SYMBOL_WORDS) +
                     ADDR_W'(item.word_index) :
                     ADDR_W'(diag[FIELD_W:0]) * ADDR_W'(MAX_SYMBOL_WORDS) +
                     ADDR_W'(item.word_index);
  end

endmodule

// ----- src/rdp_parity_encoder.sv -----
// ----------------------------------------------------------------------------
// rdp_parity_encoder
// Row-diagonal parity encoder: folds data words into row and diagonal parity
// memories, reads parity words back or clears all parity, one 64-bit word per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in_     | input     | in_valid/in_stall  | in_item_t  (request)
//  out_    | output    | out_valid/out_stall| out_item_t (parity, status)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  On acceptance an item issues reads to both parity memories; in the
//  execute state it merges, writes back and loads the result.
//  The registered read of the parity memories makes this split.
//  A held result stalls the write-back cycle, so no new item enters.
//  Reset clears the valid marks and loads the default configuration;
//  the memories need no clearing pass.
// ----------------------------------------------------------------------------
module rdp_parity_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rdp_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rdp_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [rdp_pkg::CFG_W-1:0]     cfg_data
);
  import rdp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  cfg_t               cfg_r;
  rdp_plan_t          plan;
  rdp_plan_t          plan_r;
  req_t               req_r;
  logic [DATA_W-1:0]  data_r;
  logic [STORE_DEPTH-1:0] row_mark_r, row_mark_nxt;
  logic [STORE_DEPTH-1:0] diag_mark_r, diag_mark_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic               accept;
  logic               advance;
  logic [ADDR_W-1:0]  row_raddr, diag_raddr;
  logic [DATA_W-1:0]  row_rdata, diag_rdata;
  logic [DATA_W-1:0]  row_old, diag_old;
  logic               row_we, diag_we;
  logic [DATA_W-1:0]  row_wdata, diag_wdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign advance   = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_data_chunks <= CFG_W'(4);
      cfg_r.prime_p         <= CFG_W'(5);
      cfg_r.symbol_words    <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_CHUNKS: cfg_r.num_data_chunks <= cfg_data;
        CFG_PRIME:      cfg_r.prime_p         <= cfg_data;
        CFG_SYM_WORDS:  cfg_r.symbol_words    <= cfg_data;
        default: ;
      endcase
    end
  end

  // range checks and addresses
  rdp_decode u_decode (
    .item (in_item),
    .cfg  (cfg_r),
    .plan (plan)
  );

  // read addresses come from the item on acceptance, then hold
  assign row_raddr  = (state_r == ST_IDLE) ? plan.row_addr  : plan_r.row_addr;
  assign diag_raddr = (state_r == ST_IDLE) ? plan.diag_addr : plan_r.diag_addr;

  rdp_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (plan_r.row_addr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  rdp_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_diag_ram (
    .clk   (clk),
    .we    (diag_we),
    .waddr (plan_r.diag_addr),
    .wdata (diag_wdata),
    .raddr (diag_raddr),
    .rdata (diag_rdata)
  );

  // unmarked entries read as zero
  assign row_old  = row_mark_r[plan_r.row_addr]   ? row_rdata  : '0;
  assign diag_old = diag_mark_r[plan_r.diag_addr] ? diag_rdata : '0;
  assign row_wdata  = row_old  ^ data_r;
  assign diag_wdata = diag_old ^ data_r;

  // merge, write back and result
  always_comb begin
    row_we        = 1'b0;
    diag_we       = 1'b0;
    row_mark_nxt  = row_mark_r;
    diag_mark_nxt = diag_mark_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.status      = plan_r.err;
      out_item_nxt.parity_word = '0;
      case (req_r)
        REQ_WRITE: begin
          if (!plan_r.err) begin
            row_we = 1'b1;
            row_mark_nxt[plan_r.row_addr] = 1'b1;
            if (plan_r.diag_en) begin
              diag_we = 1'b1;
              diag_mark_nxt[plan_r.diag_addr] = 1'b1;
            end
          end
        end
        REQ_ROW_RD: begin
          if (!plan_r.err) begin
            out_item_nxt.parity_word = row_old;
          end
        end
        REQ_DIAG_RD: begin
          if (!plan_r.err) begin
            out_item_nxt.parity_word = diag_old ^ (plan_r.row_fold ? row_old : '0);
          end
        end
        default: begin
          row_mark_nxt  = '0;
          diag_mark_nxt = '0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (advance) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_mark_r  <= '0;
      diag_mark_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_mark_r  <= row_mark_nxt;
      diag_mark_r <= diag_mark_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (accept) begin
      plan_r <= plan;
      req_r  <= in_item.req_type;
      data_r <= in_item.data_word;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// rdp_parity_encoder testbench
// Drives write, row read, diagonal read and clear items through the encoder
// under several stripe geometries, including unusable ones. A behavioral
// copy of the row and diagonal parity stores predicts every result, and
// results are compared field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rdp_pkg::*;

  localparam int NUM_PHASES = 14;

  // tracks row and diagonal parity the way the encoder should hold it
  class parity_tracker;
    bit [DATA_W-1:0] row_words  [STORE_DEPTH];
    bit [DATA_W-1:0] diag_words [STORE_DEPTH];
    bit              row_marked [STORE_DEPTH];
    bit              diag_marked[STORE_DEPTH];
    int unsigned     chunks;
    int unsigned     prime;
    int unsigned     sym_words;
    out_item_t       expected_parity[$];
    int              mismatches;

    function new();
      chunks     = 4;
      prime      = 5;
      sym_words  = 16;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_NUM_CHUNKS: chunks = 32'(val);
        CFG_PRIME:      prime = 32'(val);
        CFG_SYM_WORDS:  sym_words = 32'(val);
        default: ;
      endcase
    endfunction

    function bit config_ok();
      return chunks >= 1 && prime >= chunks + 1 && prime <= MAX_PRIME &&
             sym_words >= 1 && sym_words <= MAX_SYMBOL_WORDS;
    endfunction

    // note an accepted item and queue the result it should produce
    function void fold_request(in_item_t it);
      out_item_t   exp;
      int unsigned row;
      int unsigned word;
      int unsigned chunk;
      int unsigned diag;
      int unsigned parity_row;
      int unsigned ra;
      int unsigned da;
      exp   = '0;
      row   = 32'(it.row_index);
      word  = 32'(it.word_index);
      chunk = 32'(it.chunk_index);
      ra    = row * MAX_SYMBOL_WORDS + word;
      if (it.req_type == REQ_CLEAR) begin
        foreach (row_marked[i]) begin
          row_marked[i]  = 1'b0;
          diag_marked[i] = 1'b0;
        end
      end else if (!config_ok() || row >= prime - 1 || word >= sym_words) begin
        exp.status = 1'b1;
      end else if (it.req_type == REQ_WRITE) begin
        if (chunk >= chunks) begin
          exp.status = 1'b1;
        end else begin
          row_words[ra]  = row_marked[ra] ? row_words[ra] ^ it.data_word : it.data_word;
          row_marked[ra] = 1'b1;
          diag = (chunk + row) % prime;
          // the missing diagonal holds no parity
          if (diag != prime - 1) begin
            da = diag * MAX_SYMBOL_WORDS + word;
            diag_words[da]  = diag_marked[da] ? diag_words[da] ^ it.data_word
                                              : it.data_word;
            diag_marked[da] = 1'b1;
          end
        end
      end else if (it.req_type == REQ_ROW_RD) begin
        exp.parity_word = row_marked[ra] ? row_words[ra] : '0;
      end else begin
        da = ra;
        exp.parity_word = diag_marked[da] ? diag_words[da] : '0;
        // row parity column lies on this diagonal unless it hits row p-1
        parity_row = (row + prime - (chunks % prime)) % prime;
        if (parity_row != prime - 1) begin
          ra = parity_row * MAX_SYMBOL_WORDS + word;
          if (row_marked[ra]) exp.parity_word ^= row_words[ra];
        end
      end
      expected_parity = {expected_parity, exp};
    endfunction

    // compare a result with the oldest expected one
    function void match_result(out_item_t got);
      out_item_t exp;
      if (expected_parity.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual parity %h status %b",
                 $time, got.parity_word, got.status);
        mismatches++;
        return;
      end
      exp = expected_parity.pop_front();
      if (got.parity_word !== exp.parity_word) begin
        $display("%0t: parity_word mismatch, expected %h actual %h",
                 $time, exp.parity_word, got.parity_word);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch, expected %b actual %b",
                 $time, exp.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = CFG_NUM_CHUNKS;
  logic [CFG_W-1:0] cfg_data  = '0;

  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  parity_tracker tracker;

  // stripe geometries of the random part, unusable ones among them
  int phase_k [NUM_PHASES] = '{1, 0, 16, 4, 3, 2, 5, 3, 2, 3, 7, 31, 4, 1};
  int phase_p [NUM_PHASES] = '{2, 5, 17, 4, 7, 18, 6, 5, 3, 5, 11, 31, 9, 17};
  int phase_sw[NUM_PHASES] = '{1, 4, 16, 4, 4, 4, 3, 0, 16, 17, 2, 31, 8, 1};

  always #2 clk = ~clk;

  rdp_parity_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result side: check accepted items, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(out_item);
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // present one item, idling first at random, and hold it until taken
  task send_request(input req_t req, input logic [3:0] chunk, input logic [3:0] row,
                    input logic [3:0] word, input logic [DATA_W-1:0] data);
    in_item_t it;
    it.req_type    = req;
    it.chunk_index = chunk;
    it.row_index   = row;
    it.word_index  = word;
    it.data_word   = data;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    tracker.fold_request(it);
  endtask

  // hold off the sender until every pending result is back
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_parity.size() != 0);
  endtask

  // write all registers in one burst, the spare index with junk
  task set_config(input int k, input int p, input int sw);
    logic [CFG_W-1:0] vals[4];
    vals[0] = CFG_W'(k);
    vals[1] = CFG_W'(p);
    vals[2] = CFG_W'(sw);
    vals[3] = CFG_W'($urandom_range(0, 31));
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_register(cfg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly an index below the limit, sometimes any index
  function logic [3:0] pick_index(input int limit);
    if (limit >= 1 && $urandom_range(0, 99) < 90)
      return 4'($urandom_range(0, (limit > 16 ? 16 : limit) - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin
    int   roll;
    int   count;
    req_t req;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n       <= 1'b1;
    tx_idle_pct = 14;
    rx_idle_pct = 45;

    // directed part under the reset geometry k=4, p=5, 16 words
    send_request(REQ_ROW_RD,  4'd0,  4'd0,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_DIAG_RD, 4'd0,  4'd0,  4'd0,  64'h0);
    send_request(REQ_WRITE,   4'd0,  4'd0,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_WRITE,   4'd3,  4'd3,  4'd15, 64'h0123_4567_89AB_CDEF);
    // lands on the missing diagonal
    send_request(REQ_WRITE,   4'd1,  4'd3,  4'd0,  64'hDEAD_BEEF_F00D_CAFE);
    send_request(REQ_WRITE,   4'd3,  4'd0,  4'd0,  64'h0);
    send_request(REQ_ROW_RD,  4'd9,  4'd0,  4'd0,  64'h5555_5555_5555_5555);
    send_request(REQ_ROW_RD,  4'd0,  4'd3,  4'd15, 64'h0);
    send_request(REQ_DIAG_RD, 4'd0,  4'd1,  4'd15, 64'h0);
    send_request(REQ_DIAG_RD, 4'd0,  4'd0,  4'd0,  64'h0);
    send_request(REQ_DIAG_RD, 4'd0,  4'd3,  4'd0,  64'h0);
    send_request(REQ_DIAG_RD, 4'd0,  4'd2,  4'd0,  64'h0);
    // out of range chunk, row and diagonal
    send_request(REQ_WRITE,   4'd4,  4'd0,  4'd0,  64'hAAAA_AAAA_AAAA_AAAA);
    send_request(REQ_WRITE,   4'd15, 4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_ROW_RD,  4'd0,  4'd4,  4'd0,  64'h0);
    send_request(REQ_DIAG_RD, 4'd0,  4'd4,  4'd0,  64'h0);
    send_request(REQ_WRITE,   4'd0,  4'd4,  4'd1,  64'h1);
    // fold twice into the same words
    send_request(REQ_WRITE,   4'd2,  4'd2,  4'd7,  64'hA5A5_A5A5_A5A5_A5A5);
    send_request(REQ_WRITE,   4'd2,  4'd2,  4'd7,  64'h0F0F_0F0F_0F0F_0F0F);
    send_request(REQ_ROW_RD,  4'd0,  4'd2,  4'd7,  64'h0);
    // clear drops every mark, then a fresh write starts over
    send_request(REQ_CLEAR,   4'd15, 4'd15, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_ROW_RD,  4'd0,  4'd0,  4'd0,  64'h0);
    send_request(REQ_DIAG_RD, 4'd0,  4'd1,  4'd15, 64'h0);
    send_request(REQ_WRITE,   4'd0,  4'd0,  4'd0,  64'h8000_0000_0000_0001);
    send_request(REQ_ROW_RD,  4'd0,  4'd0,  4'd0,  64'h0);

    // random part, one geometry per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      set_config(phase_k[ph], phase_p[ph], phase_sw[ph]);
      if (ph < 5) begin
        tx_idle_pct = 14;
        rx_idle_pct = 45;
      end else if (ph < 10) begin
        tx_idle_pct = 45;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      count = tracker.config_ok() ? 180 : 15;
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 149) == 0) drain();
        roll = $urandom_range(0, 99);
        if (roll < 2)       req = REQ_CLEAR;
        else if (roll < 55) req = REQ_WRITE;
        else if (roll < 75) req = REQ_ROW_RD;
        else                req = REQ_DIAG_RD;
        send_request(req, pick_index(int'(tracker.chunks)),
                     pick_index(int'(tracker.prime) - 1),
                     pick_index(int'(tracker.sym_words)),
                     {$urandom, $urandom});
      end
    end

    // let the last results come home
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_parity.size() != 0);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("** rdp_parity_encoder: PASSED **");
    end else begin
      $display("** rdp_parity_encoder: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** rdp_parity_encoder: FAILED **");
    $finish;
  end

endmodule
